FILE: src/fcull_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcull_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int FRAC_BITS   = 16;
   localparam int PLANE_IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

   localparam int VAL_W    = 32;
   localparam int ACC_W    = 64;
   localparam int SUM_W    = 63;
   localparam int MARGIN_W = 31;

   localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(262144);
   localparam logic [ACC_W-1:0]    SUM_CAP      = ACC_W'(1) << 62;
   localparam logic [ACC_W-1:0]    HI_LIMIT     = ACC_W'(1) << (30 + FRAC_BITS);

   typedef logic [PLANE_IDX_W-1:0] plane_idx_type;
   typedef logic [SUM_W-1:0]       sum_type;
   typedef logic [MARGIN_W-1:0]    margin_type;

   typedef enum logic [2:0] {
      OP_PLANE  = 3'd0,
      OP_POINT  = 3'd1,
      OP_SPHERE = 3'd2,
      OP_AXIS   = 3'd3,
      OP_CENTER = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_POINT  = 2'd0,
      KIND_SPHERE = 2'd1,
      KIND_BOX    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DOT,
      S_END,
      S_AX_LO,
      S_AX_HI,
      S_AX_TERM,
      S_AX_SUM,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]              operation;
      logic [2:0]              plane_index;
      logic signed [VAL_W-1:0] x_value;
      logic signed [VAL_W-1:0] y_value;
      logic signed [VAL_W-1:0] z_value;
      logic signed [VAL_W-1:0] w_value;
   } req_type;

   typedef struct packed {
      logic       inside_res;
      logic [1:0] test_kind;
   } rsp_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
      logic signed [VAL_W-1:0] c;
      logic signed [VAL_W-1:0] d;
   } plane_type;

endpackage

`default_nettype wire

FILE: src/frustum_cull_point_sphere_obb_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Point, sphere and box center items run three products and a sign check per plane and then
// return a result; box axis items run the same dot product plus two products per plane for
// the axis term, add it into the box sums and return no result. The input stalls until an
// item is finished; plane writes leave it ready. One shared 33x33 multiplier serves all products.
// Synchronous reset clears the plane table, the box sums, the margin (to 4.0) and the result
// valid flag; the block is ready once reset is released.

module frustum_cull_point_sphere_obb_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire fcull_pkg::req_type           req_payload,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output fcull_pkg::rsp_type                rsp_payload,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [fcull_pkg::MARGIN_W-1:0] csr_data
);

   fcull_pkg::state_type     state_ff, state_in;
   fcull_pkg::plane_type     plane_ff [fcull_pkg::PLANE_COUNT];
   fcull_pkg::sum_type       sum_ff   [fcull_pkg::PLANE_COUNT];
   fcull_pkg::margin_type    margin_ff;
   fcull_pkg::req_type       item_ff;
   fcull_pkg::plane_idx_type plane_ff_idx, plane_in_idx;
   logic [1:0]               step_ff, step_in;
   logic signed [63:0]       acc_ff, acc_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic [63:0]              lo_ff, lo_in;
   logic [62:0]              term_ff, term_in;
   logic                     ok_ff, ok_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   fcull_pkg::rsp_type       rsp_ff, rsp_in;

   logic                     req_accept;
   logic                     last_plane;
   logic                     sum_write;
   logic                     sum_clear;
   logic signed [32:0]       mul_a, mul_b;
   logic signed [65:0]       mul_full;
   logic signed [63:0]       acc_next;
   logic [63:0]              acc_mag;
   logic [31:0]              ext_mag;
   logic [63:0]              shifted;
   logic [63:0]              sum_wide;
   logic signed [63:0]       base;
   fcull_pkg::plane_type     cur_plane;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != fcull_pkg::S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign cur_plane  = plane_ff[plane_ff_idx];
   assign last_plane = (plane_ff_idx == fcull_pkg::plane_idx_type'(fcull_pkg::PLANE_COUNT - 1));
   assign mul_full   = mul_a * mul_b;
   assign acc_next   = acc_ff + (prod_ff >>> fcull_pkg::FRAC_BITS);
   assign acc_mag    = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
   assign ext_mag    = item_ff.w_value[31] ? 32'(-item_ff.w_value) : 32'(item_ff.w_value);
   // Upper half product is aligned back up; the lower half was already shifted down.
   assign shifted    = (64'(prod_ff) << (32 - fcull_pkg::FRAC_BITS)) + lo_ff;
   assign sum_wide   = {1'b0, sum_ff[plane_ff_idx]} + {1'b0, term_ff};

   // Starting value of the distance sum: the plane offset plus whatever the test compares
   // against, so the final check is a sign test; box axis items start from zero.
   always_comb begin
      base = 64'(cur_plane.d);
      case (item_ff.operation)
         fcull_pkg::OP_SPHERE: base = 64'(cur_plane.d) + 64'(item_ff.w_value);
         fcull_pkg::OP_CENTER: base = 64'(cur_plane.d) + {33'b0, margin_ff}
                                      + {1'b0, sum_ff[plane_ff_idx]};
         fcull_pkg::OP_AXIS:   base = '0;
         default:              base = 64'(cur_plane.d);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      plane_in_idx = plane_ff_idx;
      step_in      = step_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      lo_in        = lo_ff;
      term_in      = term_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mul_a        = '0;
      mul_b        = '0;
      sum_write    = 1'b0;
      sum_clear    = 1'b0;

      unique case (state_ff)
         fcull_pkg::S_IDLE: begin
            plane_in_idx = '0;
            step_in      = '0;
            ok_in        = 1'b1;
            if (req_accept) begin
               if (req_payload.operation == fcull_pkg::OP_POINT ||
                   req_payload.operation == fcull_pkg::OP_SPHERE ||
                   req_payload.operation == fcull_pkg::OP_AXIS ||
                   req_payload.operation == fcull_pkg::OP_CENTER) begin
                  state_in = fcull_pkg::S_DOT;
               end
            end
         end
         fcull_pkg::S_DOT: begin
            case (step_ff)
               2'd0: begin
                  mul_a = 33'(cur_plane.a);
                  mul_b = 33'(item_ff.x_value);
               end
               2'd1: begin
                  mul_a = 33'(cur_plane.b);
                  mul_b = 33'(item_ff.y_value);
               end
               default: begin
                  mul_a = 33'(cur_plane.c);
                  mul_b = 33'(item_ff.z_value);
               end
            endcase
            prod_in = mul_full[63:0];
            acc_in  = (step_ff == 2'd0) ? base : acc_next;
            if (step_ff == 2'd2) begin
               step_in  = '0;
               state_in = fcull_pkg::S_END;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         fcull_pkg::S_END: begin
            acc_in = acc_next;
            if (item_ff.operation == fcull_pkg::OP_AXIS) begin
               state_in = fcull_pkg::S_AX_LO;
            end else begin
               if (item_ff.operation == fcull_pkg::OP_CENTER) begin
                  ok_in = ok_ff && (acc_next > 0);
               end else begin
                  ok_in = ok_ff && !acc_next[63];
               end
               if (last_plane) begin
                  state_in = fcull_pkg::S_DONE;
               end else begin
                  plane_in_idx = plane_ff_idx + 1'b1;
                  state_in     = fcull_pkg::S_DOT;
               end
            end
         end
         fcull_pkg::S_AX_LO: begin
            mul_a    = {1'b0, acc_mag[31:0]};
            mul_b    = {1'b0, ext_mag};
            prod_in  = mul_full[63:0];
            state_in = fcull_pkg::S_AX_HI;
         end
         fcull_pkg::S_AX_HI: begin
            mul_a    = {1'b0, acc_mag[63:32]};
            mul_b    = {1'b0, ext_mag};
            prod_in  = mul_full[63:0];
            lo_in    = 64'(prod_ff) >> fcull_pkg::FRAC_BITS;
            state_in = fcull_pkg::S_AX_TERM;
         end
         fcull_pkg::S_AX_TERM: begin
            if (64'(prod_ff) > fcull_pkg::HI_LIMIT || shifted > fcull_pkg::SUM_CAP) begin
               term_in = fcull_pkg::SUM_CAP[62:0];
            end else begin
               term_in = shifted[62:0];
            end
            state_in = fcull_pkg::S_AX_SUM;
         end
         fcull_pkg::S_AX_SUM: begin
            sum_write = 1'b1;
            if (last_plane) begin
               state_in = fcull_pkg::S_IDLE;
            end else begin
               plane_in_idx = plane_ff_idx + 1'b1;
               state_in     = fcull_pkg::S_DOT;
            end
         end
         fcull_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.inside_res = ok_ff;
               case (item_ff.operation)
                  fcull_pkg::OP_POINT:  rsp_in.test_kind = fcull_pkg::KIND_POINT;
                  fcull_pkg::OP_SPHERE: rsp_in.test_kind = fcull_pkg::KIND_SPHERE;
                  default:              rsp_in.test_kind = fcull_pkg::KIND_BOX;
               endcase
               sum_clear = (item_ff.operation == fcull_pkg::OP_CENTER);
               state_in  = fcull_pkg::S_IDLE;
            end
         end
         default: state_in = fcull_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcull_pkg::S_IDLE;
         plane_ff_idx <= '0;
         step_ff      <= '0;
         ok_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
         margin_ff    <= fcull_pkg::MARGIN_RESET;
      end else begin
         state_ff     <= state_in;
         plane_ff_idx <= plane_in_idx;
         step_ff      <= step_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            margin_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      lo_ff   <= lo_in;
      term_ff <= term_in;
      rsp_ff  <= rsp_in;
      if (req_accept) begin
         item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin
            plane_ff[i] <= '0;
            sum_ff[i]   <= '0;
         end
      end else begin
         if (req_accept && req_payload.operation == fcull_pkg::OP_PLANE &&
             32'(req_payload.plane_index) < fcull_pkg::PLANE_COUNT) begin
            plane_ff[fcull_pkg::plane_idx_type'(req_payload.plane_index)] <=
               {req_payload.x_value, req_payload.y_value,
                req_payload.z_value, req_payload.w_value};
         end
         if (sum_clear) begin
            for (int i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin
               sum_ff[i] <= '0;
            end
         end else if (sum_write) begin
            sum_ff[plane_ff_idx] <= (sum_wide > fcull_pkg::SUM_CAP) ?
                                    fcull_pkg::SUM_CAP[62:0] : sum_wide[62:0];
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/fcull_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fcull_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire fcull_pkg::req_type             req_payload,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire fcull_pkg::rsp_type             rsp_payload,
   input wire logic                           csr_valid,
   input wire logic                           csr_ready,
   input wire logic [fcull_pkg::MARGIN_W-1:0] csr_data
);

   logic req_accept;
   logic test_op;

   assign req_accept = req_valid && !req_stall;
   assign test_op = (req_payload.operation == fcull_pkg::OP_POINT) ||
                    (req_payload.operation == fcull_pkg::OP_SPHERE) ||
                    (req_payload.operation == fcull_pkg::OP_AXIS) ||
                    (req_payload.operation == fcull_pkg::OP_CENTER);

   // A held result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Reset leaves the block empty and ready.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // Any item that runs over the planes keeps the input side busy afterwards.
   a_busy_after_test: assert property (@(posedge clock) disable iff (reset)
      req_accept && test_op |=> req_stall)
      else $error("input not stalled while an item is in work");

   // A plane write leaves the input ready and produces no result.
   a_plane_write: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.operation == fcull_pkg::OP_PLANE && !rsp_valid
      |=> !req_stall && !rsp_valid)
      else $error("plane write did not complete at once");

   // A test item must not produce an early result.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept && test_op && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
      else $error("result appeared too early");

endmodule

bind frustum_cull_point_sphere_obb_unit fcull_checker u_fcull_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready),
   .csr_data    (csr_data)
);

`default_nettype wire
